/* hdl/sample_average_gamma2_quantize_macros.svh */
// Assertion helpers for the tone map block
`ifndef SAMPLE_AVERAGE_GAMMA2_QUANTIZE_MACROS_SVH
`define SAMPLE_AVERAGE_GAMMA2_QUANTIZE_MACROS_SVH

// Check an implication on every clock edge outside reset
`define SAGQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check an implication in the cycle after the antecedent
`define SAGQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/sagq_pkg.sv */
`timescale 1ns / 1ps
package sagq_pkg;
   localparam int SumWidth   = 32;
   localparam int CountWidth = 16;
   localparam int ByteWidth  = 8;
   localparam int RootWidth  = 16;
   localparam int Channels   = 3;
   localparam logic [SumWidth-1:0] SatLimit = 32'd65025;
   localparam logic [ByteWidth-1:0] ByteMax = 8'd255;
   // Quotient bits resolved per divider cell
   localparam int DivBitsPerCell = 2;
   localparam int DivCells       = SumWidth / DivBitsPerCell;
   // One root bit per root cell
   localparam int RootCells      = ByteWidth;

   // Division working word for one channel
   typedef struct packed {
      logic [SumWidth-1:0]   rem;
      logic [SumWidth-1:0]   quo;
      logic [SumWidth-1:0]   num;
   } div_lane_type;

   // Root working word for one channel
   typedef struct packed {
      logic [RootWidth-1:0] x;
      logic [RootWidth-1:0] root;
      logic                 sat;
   } root_lane_type;
endpackage

/* hdl/sagq_div_cell.sv */
`timescale 1ns / 1ps
module sagq_div_cell #(
   parameter int Index = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                valid_in,
   input  logic                                advance,
   input  logic [sagq_pkg::CountWidth-1:0]     divisor_in,
   input  sagq_pkg::div_lane_type              lane_in [sagq_pkg::Channels],
   output logic                                valid_out,
   output logic [sagq_pkg::CountWidth-1:0]     divisor_out,
   output sagq_pkg::div_lane_type              lane_out [sagq_pkg::Channels]
);
   logic                                valid_ff;
   logic [sagq_pkg::CountWidth-1:0]     divisor_ff;
   sagq_pkg::div_lane_type              lane_ff [sagq_pkg::Channels];
   sagq_pkg::div_lane_type              lane_in_c [sagq_pkg::Channels];

   // Resolve two quotient bits, most significant first
   always_comb begin
      logic [sagq_pkg::SumWidth:0] trial;
      logic [sagq_pkg::SumWidth-1:0] r;
      logic [sagq_pkg::SumWidth-1:0] q;
      int bpos;
      for (int c = 0; c < sagq_pkg::Channels; c++) begin
         r = lane_in[c].rem;
         q = lane_in[c].quo;
         for (int k = 0; k < sagq_pkg::DivBitsPerCell; k++) begin
            bpos = sagq_pkg::SumWidth - 1 - Index * sagq_pkg::DivBitsPerCell - k;
            trial = {r, lane_in[c].num[bpos]};
            if (trial >= {{(sagq_pkg::SumWidth-sagq_pkg::CountWidth+1){1'b0}}, divisor_in})
               begin
               trial = trial - {{(sagq_pkg::SumWidth-sagq_pkg::CountWidth+1){1'b0}},
                  divisor_in};
               q[bpos] = 1'b1;
            end else begin
               q[bpos] = 1'b0;
            end
            r = trial[sagq_pkg::SumWidth-1:0];
         end
         lane_in_c[c].rem = r;
         lane_in_c[c].quo = q;
         lane_in_c[c].num = lane_in[c].num;
      end
   end

   // Advance when the chain moves
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         divisor_ff <= divisor_in;
         lane_ff    <= lane_in_c;
      end
   end

   assign valid_out   = valid_ff;
   assign divisor_out = divisor_ff;
   assign lane_out    = lane_ff;
endmodule

/* hdl/sagq_root_cell.sv */
`timescale 1ns / 1ps
module sagq_root_cell #(
   parameter int Index = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  logic                   advance,
   input  sagq_pkg::root_lane_type lane_in [sagq_pkg::Channels],
   output logic                   valid_out,
   output sagq_pkg::root_lane_type lane_out [sagq_pkg::Channels]
);
   localparam logic [sagq_pkg::RootWidth-1:0] Bit =
      sagq_pkg::RootWidth'(1) << (2 * (sagq_pkg::RootCells - 1 - Index));

   logic                    valid_ff;
   sagq_pkg::root_lane_type lane_ff [sagq_pkg::Channels];
   sagq_pkg::root_lane_type lane_c  [sagq_pkg::Channels];

   // One digit step of the bitwise square root
   always_comb begin
      for (int c = 0; c < sagq_pkg::Channels; c++) begin
         lane_c[c].sat = lane_in[c].sat;
         if (lane_in[c].x >= lane_in[c].root + Bit) begin
            lane_c[c].x    = lane_in[c].x - (lane_in[c].root + Bit);
            lane_c[c].root = (lane_in[c].root >> 1) + Bit;
         end else begin
            lane_c[c].x    = lane_in[c].x;
            lane_c[c].root = lane_in[c].root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         lane_ff <= lane_c;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;
endmodule

/* hdl/sample_average_gamma2_quantize.sv */
`timescale 1ns / 1ps
// Pipeline: 16 divider cells, 8 root cells and an output register from accepted word to result.
// Throughput: one word per cycle; the divider and root chains each resolve a fixed
// number of bits per cell, so a new word enters every cycle the chain advances.
// Reset (synchronous, active high) clears all valid flags and sets sample_count to 1.
module sample_average_gamma2_quantize (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sagq_pkg::CountWidth-1:0]   csr_sample_count,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sagq_pkg::SumWidth-1:0]     req_red_sum,
   input  logic [sagq_pkg::SumWidth-1:0]     req_green_sum,
   input  logic [sagq_pkg::SumWidth-1:0]     req_blue_sum,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sagq_pkg::ByteWidth-1:0]    rsp_red_byte,
   output logic [sagq_pkg::ByteWidth-1:0]    rsp_green_byte,
   output logic [sagq_pkg::ByteWidth-1:0]    rsp_blue_byte
);
`include "sample_average_gamma2_quantize_macros.svh"

   localparam int DC = sagq_pkg::DivCells;
   localparam int RC = sagq_pkg::RootCells;

   logic [sagq_pkg::CountWidth-1:0] count_ff;
   logic                            advance;
   logic                            out_valid_ff;
   logic [sagq_pkg::ByteWidth-1:0]  out_byte_ff [sagq_pkg::Channels];

   logic                            dv [DC+1];
   logic [sagq_pkg::CountWidth-1:0] dd [DC+1];
   sagq_pkg::div_lane_type          dl [DC+1][sagq_pkg::Channels];
   logic                            rv [RC+1];
   sagq_pkg::root_lane_type         rl [RC+1][sagq_pkg::Channels];
   logic [sagq_pkg::SumWidth-1:0]   sums [sagq_pkg::Channels];

   // Hold the sample count; treat zero as one
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= sagq_pkg::CountWidth'(1);
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_sample_count;
      end
   end
   assign csr_ready = 1'b1;

   // Whole chain moves unless a result is stuck at the output
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign sums[0] = req_red_sum;
   assign sums[1] = req_green_sum;
   assign sums[2] = req_blue_sum;

   assign dv[0] = req_valid;
   assign dd[0] = (count_ff == '0) ? sagq_pkg::CountWidth'(1) : count_ff;
   always_comb begin
      for (int c = 0; c < sagq_pkg::Channels; c++) begin
         dl[0][c].rem = '0;
         dl[0][c].quo = '0;
         dl[0][c].num = sums[c];
      end
   end

   for (genvar i = 0; i < DC; i++) begin : g_div
      sagq_div_cell #(.Index(i)) u_cell (
         .clock(clock), .reset(reset), .valid_in(dv[i]), .advance(advance),
         .divisor_in(dd[i]), .lane_in(dl[i]), .valid_out(dv[i+1]),
         .divisor_out(dd[i+1]), .lane_out(dl[i+1])
      );
   end

   // Drop into the root chain, flag saturation
   assign rv[0] = dv[DC];
   always_comb begin
      for (int c = 0; c < sagq_pkg::Channels; c++) begin
         rl[0][c].sat  = dl[DC][c].quo >= sagq_pkg::SatLimit;
         rl[0][c].x    = dl[DC][c].quo[sagq_pkg::RootWidth-1:0];
         rl[0][c].root = '0;
      end
   end

   for (genvar i = 0; i < RC; i++) begin : g_root
      sagq_root_cell #(.Index(i)) u_cell (
         .clock(clock), .reset(reset), .valid_in(rv[i]), .advance(advance),
         .lane_in(rl[i]), .valid_out(rv[i+1]), .lane_out(rl[i+1])
      );
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= rv[RC];
      end
      if (advance) begin
         for (int c = 0; c < sagq_pkg::Channels; c++) begin
            out_byte_ff[c] <= rl[RC][c].sat ? sagq_pkg::ByteMax
                            : rl[RC][c].root[sagq_pkg::ByteWidth-1:0];
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_red_byte   = out_byte_ff[0];
   assign rsp_green_byte = out_byte_ff[1];
   assign rsp_blue_byte  = out_byte_ff[2];

   `SAGQ_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SAGQ_ASSERT_IMP(a_ready_rule, clock, reset, !rsp_valid, req_ready)
   `SAGQ_ASSERT_IMP(a_divisor_nonzero, clock, reset, 1'b1, dd[0] != '0)
endmodule
